// ----- rtl/cas_pkg.sv -----
// Shared types and constants for the cave automaton smoother.
// Used by the interfaces, the control block and the top level; no dependencies.
`default_nettype none

package cas_pkg;

	// Fixed payload widths
	localparam int ROW_BITS  = 64;
	localparam int ROW_NUM_W = 6;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;
	localparam int CFG_W      = 7;
	localparam int LIMIT_W    = 4;
	localparam int GEN_W      = 4;

	// Default size limits
	localparam int DEF_MAX_WIDTH  = 64;
	localparam int DEF_MAX_HEIGHT = 64;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAP_WIDTH        = 3'd0,
		REG_MAP_HEIGHT       = 3'd1,
		REG_BIRTH_LIMIT      = 3'd2,
		REG_DEATH_LIMIT      = 3'd3,
		REG_GENERATION_COUNT = 3'd4
	} cfg_reg_t;

	// Configuration register set
	typedef struct packed {
		logic [CFG_W-1:0]   map_width;
		logic [CFG_W-1:0]   map_height;
		logic [LIMIT_W-1:0] birth_limit;
		logic [LIMIT_W-1:0] death_limit;
		logic [GEN_W-1:0]   generation_count;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		map_width:        7'd64,
		map_height:       7'd64,
		birth_limit:      4'd4,
		death_limit:      4'd3,
		generation_count: 4'd5
	};

endpackage

`default_nettype wire

// ----- rtl/cas_if.sv -----
// Channel interfaces: input rows, result rows and the configuration write channel.
// Depends on cas_pkg for payload widths.
`default_nettype none

interface cas_row_if;
	import cas_pkg::*;
	logic                valid;
	logic                ready;
	logic [ROW_BITS-1:0] row_cells;

	modport source (output valid, output row_cells, input ready);
	modport sink   (input valid, input row_cells, output ready);
endinterface

interface cas_res_if;
	import cas_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [ROW_BITS-1:0]  out_cells;
	logic [ROW_NUM_W-1:0] row_number;
	logic                 last_row;

	modport source (output valid, output out_cells, output row_number, output last_row,
		input ready);
	modport sink   (input valid, input out_cells, input row_number, input last_row,
		output ready);
endinterface

interface cas_cfg_if;
	import cas_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  reg_index;
	logic [CFG_DATA_W-1:0] wdata;

	modport source (output valid, output reg_index, output wdata, input ready);
	modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

// ----- rtl/cave_automaton_smoother.sv -----
// Top level of the cave smoother: configuration registers and the sequencer.
// Depends on cas_pkg, cas_if and cas_ctrl.
`default_nettype none

// Cave smoother. Rows of a wall/floor bitmap enter one per cycle on rows (bit x set
// for a wall). The row that completes a frame of map_height rows starts
// generation_count sweeps of the birth/death automaton; cells outside the map count
// as walls. Each sweep reads the previous generation from one RAM bank and writes the
// next one to the other, one row per cycle through a three-row window. In read-out
// each row is read from the one read port of its bank and then loaded into a single
// result register before the next row is read. rows is not ready from the completing
// row until the last result row is loaded. Configuration writes are taken every cycle
// and should be made only while the block is idle.
module cave_automaton_smoother
	import cas_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  wire logic clk,
	input  wire logic arst_n,
	cas_row_if.sink   rows,
	cas_res_if.source results,
	cas_cfg_if.sink   cfg
);

	cfg_t cfg_q;

	assign cfg.ready = 1'b1;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_reg_t'(cfg.reg_index))
				REG_MAP_WIDTH:        cfg_q.map_width        <= cfg.wdata;
				REG_MAP_HEIGHT:       cfg_q.map_height       <= cfg.wdata;
				REG_BIRTH_LIMIT:      cfg_q.birth_limit      <= cfg.wdata[LIMIT_W-1:0];
				REG_DEATH_LIMIT:      cfg_q.death_limit      <= cfg.wdata[LIMIT_W-1:0];
				REG_GENERATION_COUNT: cfg_q.generation_count <= cfg.wdata[GEN_W-1:0];
				default: ;
			endcase
		end
	end

	cas_ctrl #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_q  (cfg_q),
		.rows   (rows),
		.results(results)
	);

endmodule

`default_nettype wire

// ----- rtl/cas_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cas_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/cas_rule.sv -----
// Birth/death rule for one whole row: neighbor wall count and next cell state per column.
// Depends on cas_pkg for the limit width.
`default_nettype none

module cas_rule
	import cas_pkg::*;
#(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  wire logic [MAX_WIDTH-1:0] above,
	input  wire logic [MAX_WIDTH-1:0] center,
	input  wire logic [MAX_WIDTH-1:0] below,
	input  wire logic [MAX_WIDTH-1:0] width_mask,
	input  wire logic [LIMIT_W-1:0]   birth_limit,
	input  wire logic [LIMIT_W-1:0]   death_limit,
	output      logic [MAX_WIDTH-1:0] next_row
);

	// Rows padded by one wall column on each side; columns past the width are walls
	logic [MAX_WIDTH+1:0] pad_a, pad_c, pad_b;

	assign pad_a = {1'b1, above  | ~width_mask, 1'b1};
	assign pad_c = {1'b1, center | ~width_mask, 1'b1};
	assign pad_b = {1'b1, below  | ~width_mask, 1'b1};

	// Per-column count and rule, lanes are independent
	always_comb begin
		logic [LIMIT_W-1:0] cnt;
		logic               wall;
		for (int x = 0; x < MAX_WIDTH; x++) begin
			cnt = LIMIT_W'(pad_a[x]) + LIMIT_W'(pad_a[x+1]) + LIMIT_W'(pad_a[x+2])
				+ LIMIT_W'(pad_c[x]) + LIMIT_W'(pad_c[x+2])
				+ LIMIT_W'(pad_b[x]) + LIMIT_W'(pad_b[x+1]) + LIMIT_W'(pad_b[x+2]);
			if (center[x]) begin
				wall = (cnt >= death_limit);
			end else begin
				wall = (cnt > birth_limit);
			end
			next_row[x] = wall & width_mask[x];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/cas_ctrl.sv -----
// Sequencer of the smoother: row loading, generation sweeps over two ping-pong RAMs
// with a three-row window, and result read-out. Depends on cas_pkg, cas_if, cas_ram, cas_rule.
`default_nettype none

module cas_ctrl
	import cas_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg_q,
	cas_row_if.sink    rows,
	cas_res_if.source  results
);

	localparam int AW = $clog2(MAX_HEIGHT);
	localparam int HW = $clog2(MAX_HEIGHT + 1);

	typedef enum logic [4:0] {
		S_LOAD   = 5'b00001,
		S_GEN    = 5'b00010,
		S_DRAIN  = 5'b00100,
		S_OUT_RD = 5'b01000,
		S_OUT_LD = 5'b10000
	} state_t;

	state_t state_q;

	logic [HW-1:0]    rows_loaded_q;
	logic [HW-1:0]    step_q;
	logic [GEN_W-1:0] gen_left_q;
	logic             src_bank_q;
	logic [AW-1:0]    out_y_q;

	logic             vld_s1;
	logic [HW-1:0]    step_s1;

	logic [MAX_WIDTH-1:0] top_q, mid_q;

	logic                 out_valid_q;
	logic [ROW_BITS-1:0]  out_cells_q;
	logic [ROW_NUM_W-1:0] row_number_q;
	logic                 last_row_q;

	logic [MAX_WIDTH-1:0] width_mask;
	logic [MAX_WIDTH-1:0] walls;
	logic [CFG_W-1:0]     eff_height;

	logic in_acc, load_done, gen_rd, out_free, out_rd, rd_en, is_last;
	logic [AW-1:0] rd_addr;
	logic [MAX_WIDTH-1:0] rdata0, rdata1, rd_masked, bot_row, next_row;
	logic row_end_s1, gen_we;
	logic [HW-1:0] step_m1;
	logic [AW-1:0] gen_waddr;
	logic we0, we1;
	logic [AW-1:0] waddr0;
	logic [MAX_WIDTH-1:0] wdata0;

	// Width mask and clamped height
	always_comb begin
		for (int x = 0; x < MAX_WIDTH; x++) begin
			width_mask[x] = (CFG_W'(x) < cfg_q.map_width);
		end
	end

	assign walls = '1;

	always_comb begin
		if (cfg_q.map_height == '0) begin
			eff_height = CFG_W'(1);
		end else if (cfg_q.map_height > CFG_W'(MAX_HEIGHT)) begin
			eff_height = CFG_W'(MAX_HEIGHT);
		end else begin
			eff_height = cfg_q.map_height;
		end
	end

	// Handshake and read requests
	assign rows.ready = (state_q == S_LOAD);
	assign in_acc     = rows.valid && rows.ready;
	assign load_done  = (CFG_W'(rows_loaded_q) + CFG_W'(1)) >= eff_height;
	assign gen_rd     = (state_q == S_GEN) && (CFG_W'(step_q) < eff_height);
	assign out_free   = !out_valid_q || results.ready;
	assign out_rd     = (state_q == S_OUT_RD) && out_free;
	assign rd_en      = gen_rd || out_rd;
	assign rd_addr    = (state_q == S_GEN) ? step_q[AW-1:0] : out_y_q;
	assign is_last    = (CFG_W'(out_y_q) == (eff_height - CFG_W'(1)));

	assign rd_masked  = (src_bank_q ? rdata1 : rdata0) & width_mask;

	// Window stage: row step_s1 arrives, row step_s1-1 is computed
	assign row_end_s1 = (CFG_W'(step_s1) == eff_height);
	assign bot_row    = row_end_s1 ? walls : rd_masked;
	assign gen_we     = vld_s1 && (step_s1 != '0);
	assign step_m1    = step_s1 - HW'(1);
	assign gen_waddr  = step_m1[AW-1:0];

	cas_rule #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_rule (
		.above      (top_q),
		.center     (mid_q),
		.below      (bot_row),
		.width_mask (width_mask),
		.birth_limit(cfg_q.birth_limit),
		.death_limit(cfg_q.death_limit),
		.next_row   (next_row)
	);

	// Bank 0 takes loaded rows and even destination writes; bank 1 only sweep writes
	assign we0    = in_acc || (gen_we && src_bank_q);
	assign waddr0 = in_acc ? rows_loaded_q[AW-1:0] : gen_waddr;
	assign wdata0 = in_acc ? (rows.row_cells[MAX_WIDTH-1:0] & width_mask) : next_row;
	assign we1    = gen_we && !src_bank_q;

	cas_ram #(
		.WIDTH(MAX_WIDTH),
		.DEPTH(MAX_HEIGHT)
	) u_bank0 (
		.clk  (clk),
		.we   (we0),
		.waddr(waddr0),
		.wdata(wdata0),
		.re   (rd_en && !src_bank_q),
		.raddr(rd_addr),
		.rdata(rdata0)
	);

	cas_ram #(
		.WIDTH(MAX_WIDTH),
		.DEPTH(MAX_HEIGHT)
	) u_bank1 (
		.clk  (clk),
		.we   (we1),
		.waddr(gen_waddr),
		.wdata(next_row),
		.re   (rd_en && src_bank_q),
		.raddr(rd_addr),
		.rdata(rdata1)
	);

	// Main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_LOAD;
			rows_loaded_q <= '0;
			step_q        <= '0;
			gen_left_q    <= '0;
			src_bank_q    <= 1'b0;
			out_y_q       <= '0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (load_done) begin
							rows_loaded_q <= '0;
							src_bank_q    <= 1'b0;
							step_q        <= '0;
							out_y_q       <= '0;
							gen_left_q    <= cfg_q.generation_count;
							state_q       <= (cfg_q.generation_count == '0) ? S_OUT_RD : S_GEN;
						end else begin
							rows_loaded_q <= rows_loaded_q + HW'(1);
						end
					end
				end
				S_GEN: begin
					step_q <= step_q + HW'(1);
					if (CFG_W'(step_q) == eff_height) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					src_bank_q <= !src_bank_q;
					step_q     <= '0;
					gen_left_q <= gen_left_q - GEN_W'(1);
					state_q    <= (gen_left_q == GEN_W'(1)) ? S_OUT_RD : S_GEN;
				end
				S_OUT_RD: begin
					if (out_free) begin
						state_q <= S_OUT_LD;
					end
				end
				S_OUT_LD: begin
					if (is_last) begin
						state_q <= S_LOAD;
					end else begin
						out_y_q <= out_y_q + AW'(1);
						state_q <= S_OUT_RD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// Read pipeline tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= (state_q == S_GEN);
		end
	end

	always_ff @(posedge clk) begin
		step_s1 <= step_q;
	end

	// Three-row window; the row above the map is all walls
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			if (step_s1 == '0) begin
				top_q <= walls;
			end else begin
				top_q <= mid_q;
			end
			mid_q <= bot_row;
		end
	end

	// Result output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT_LD) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT_LD) begin
			out_cells_q  <= ROW_BITS'(rd_masked);
			row_number_q <= ROW_NUM_W'(out_y_q);
			last_row_q   <= is_last;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.out_cells  = out_cells_q;
	assign results.row_number = row_number_q;
	assign results.last_row   = last_row_q;

endmodule

`default_nettype wire

// ----- rtl/cas_checker.sv -----
// Port-level checks for the cave smoother, attached to the top level by bind.
// Depends on cas_pkg for payload widths.
`default_nettype none

module cas_checker
	import cas_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_ready,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire logic [ROW_BITS-1:0]  out_cells,
	input wire logic [ROW_NUM_W-1:0] row_number,
	input wire logic                 last_row
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_cells)
			&& $stable(row_number) && $stable(last_row))
		else $error("result changed while stalled");

	// No new frame is taken while a non-final row is pending
	a_no_load_mid_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_row |-> !in_ready)
		else $error("input ready while result frame incomplete");

	// After a non-final row is taken the block keeps emitting
	a_busy_after_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_row |=> !in_ready)
		else $error("input ready right after a non-final row");

	// A follow-on row is read and loaded only after the previous one was taken
	a_row_follows: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) && row_number != '0 |-> $past(out_valid && out_ready, 2))
		else $error("row shown without preceding transaction");

	// An input row is taken only while the final row of a frame, if any, waits
	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && out_valid |-> last_row)
		else $error("input taken while a non-final row waits");

endmodule

bind cave_automaton_smoother cas_checker u_cas_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (rows.valid),
	.in_ready  (rows.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_cells (results.out_cells),
	.row_number(results.row_number),
	.last_row  (results.last_row)
);

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for cave_automaton_smoother: directed table, then random frames.
// Depends on cas_pkg, the cas_if channel interfaces and the RTL top level.

module tb_top;
	import cas_pkg::*;

	localparam int MAX_W          = DEF_MAX_WIDTH;
	localparam int MAX_H          = DEF_MAX_HEIGHT;
	localparam int SETTLE_CYCLES  = 8;
	localparam int DRAIN_CYCLES   = 200;
	localparam int PHASE_ITEMS    = 97;
	localparam longint TIMEOUT_NS = 5_000_000;

	typedef struct packed {
		logic [ROW_BITS-1:0]  cells;
		logic [ROW_NUM_W-1:0] row;
		logic                 is_last;
	} frame_row_t;

	typedef enum logic {STEP_REG, STEP_ROW} step_kind_t;

	typedef struct packed {
		step_kind_t            kind;
		cfg_reg_t              reg_sel;
		logic [CFG_DATA_W-1:0] value;
		logic [ROW_BITS-1:0]   cells;
		logic                  pinned;
		logic [ROW_BITS-1:0]   want;
	} script_step_t;

	localparam int DIRECTED_STEPS = 53;

	// Directed table; a pinned row gives the expected out_cells of its map row
	localparam script_step_t SCRIPT [DIRECTED_STEPS] = '{
		// 3x3, no generations: rows pass through masked
		'{STEP_REG, REG_MAP_WIDTH,        7'd3,   '0, 1'b0, '0},
		'{STEP_REG, REG_MAP_HEIGHT,       7'd3,   '0, 1'b0, '0},
		'{STEP_REG, REG_GENERATION_COUNT, 7'd0,   '0, 1'b0, '0},
		'{STEP_REG, REG_BIRTH_LIMIT,      7'd4,   '0, 1'b0, '0},
		'{STEP_REG, REG_DEATH_LIMIT,      7'd3,   '0, 1'b0, '0},
		'{STEP_ROW, REG_MAP_WIDTH, 7'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h7},
		'{STEP_ROW, REG_MAP_WIDTH, 7'd0, 64'h0,                   1'b1, 64'h0},
		'{STEP_ROW, REG_MAP_WIDTH, 7'd0, 64'hAAAA_AAAA_AAAA_AAA5, 1'b1, 64'h5},
		// zero width has no cells; zero height acts as one row
		'{STEP_REG, REG_MAP_WIDTH,        7'd0,   '0, 1'b0, '0},
		'{STEP_REG, REG_MAP_HEIGHT,       7'd0,   '0, 1'b0, '0},
		'{STEP_REG, REG_GENERATION_COUNT, 7'd15,  '0, 1'b0, '0},
		'{STEP_ROW, REG_MAP_WIDTH, 7'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0},
		// width clamps to 64; walls never die, floors never born
		'{STEP_REG, REG_MAP_WIDTH,        7'd127, '0, 1'b0, '0},
		'{STEP_REG, REG_MAP_HEIGHT,       7'd2,   '0, 1'b0, '0},
		'{STEP_REG, REG_GENERATION_COUNT, 7'd1,   '0, 1'b0, '0},
		'{STEP_REG, REG_BIRTH_LIMIT,      7'd8,   '0, 1'b0, '0},
		'{STEP_REG, REG_DEATH_LIMIT,      7'd0,   '0, 1'b0, '0},
		'{STEP_ROW, REG_MAP_WIDTH, 7'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
		'{STEP_ROW, REG_MAP_WIDTH, 7'd0, 64'h8000_0000_0000_0001, 1'b1, 64'h8000_0000_0000_0001},
		// death limit above 8 clears every wall
		'{STEP_REG, REG_BIRTH_LIMIT,      7'd15,  '0, 1'b0, '0},
		'{STEP_REG, REG_DEATH_LIMIT,      7'd9,   '0, 1'b0, '0},
		'{STEP_ROW, REG_MAP_WIDTH, 7'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0},
		'{STEP_ROW, REG_MAP_WIDTH, 7'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0},
		// solid rock stays solid at death limit 8
		'{STEP_REG, REG_MAP_WIDTH,        7'd5,   '0, 1'b0, '0},
		'{STEP_REG, REG_MAP_HEIGHT,       7'd4,   '0, 1'b0, '0},
		'{STEP_REG, REG_GENERATION_COUNT, 7'd3,   '0, 1'b0, '0},
		'{STEP_REG, REG_BIRTH_LIMIT,      7'd0,   '0, 1'b0, '0},
		'{STEP_REG, REG_DEATH_LIMIT,      7'd8,   '0, 1'b0, '0},
		'{STEP_ROW, REG_MAP_WIDTH, 7'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h1F},
		'{STEP_ROW, REG_MAP_WIDTH, 7'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h1F},
		'{STEP_ROW, REG_MAP_WIDTH, 7'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h1F},
		'{STEP_ROW, REG_MAP_WIDTH, 7'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h1F},
		// open floor with birth limit 8 stays open
		'{STEP_REG, REG_MAP_WIDTH,        7'd64,  '0, 1'b0, '0},
		'{STEP_REG, REG_MAP_HEIGHT,       7'd1,   '0, 1'b0, '0},
		'{STEP_REG, REG_BIRTH_LIMIT,      7'd8,   '0, 1'b0, '0},
		'{STEP_ROW, REG_MAP_WIDTH, 7'd0, 64'h0, 1'b1, 64'h0},
		// height lowered under the rows already loaded
		'{STEP_REG, REG_MAP_WIDTH,        7'd8,   '0, 1'b0, '0},
		'{STEP_REG, REG_MAP_HEIGHT,       7'd6,   '0, 1'b0, '0},
		'{STEP_REG, REG_GENERATION_COUNT, 7'd1,   '0, 1'b0, '0},
		'{STEP_REG, REG_BIRTH_LIMIT,      7'd4,   '0, 1'b0, '0},
		'{STEP_REG, REG_DEATH_LIMIT,      7'd3,   '0, 1'b0, '0},
		'{STEP_ROW, REG_MAP_WIDTH, 7'd0, 64'hFF00_0000_0000_00A5, 1'b0, '0},
		'{STEP_ROW, REG_MAP_WIDTH, 7'd0, 64'h3C, 1'b0, '0},
		'{STEP_ROW, REG_MAP_WIDTH, 7'd0, 64'h81, 1'b0, '0},
		'{STEP_ROW, REG_MAP_WIDTH, 7'd0, 64'h5A, 1'b0, '0},
		'{STEP_REG, REG_MAP_HEIGHT,       7'd2,   '0, 1'b0, '0},
		'{STEP_ROW, REG_MAP_WIDTH, 7'd0, 64'hFF, 1'b0, '0},
		// width narrowed halfway through a frame
		'{STEP_REG, REG_MAP_HEIGHT,       7'd4,   '0, 1'b0, '0},
		'{STEP_ROW, REG_MAP_WIDTH, 7'd0, 64'hFF, 1'b0, '0},
		'{STEP_ROW, REG_MAP_WIDTH, 7'd0, 64'hF0, 1'b0, '0},
		'{STEP_REG, REG_MAP_WIDTH,        7'd5,   '0, 1'b0, '0},
		'{STEP_ROW, REG_MAP_WIDTH, 7'd0, 64'hFF, 1'b0, '0},
		'{STEP_ROW, REG_MAP_WIDTH, 7'd0, 64'h0F, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n;

	cas_row_if row_ch ();
	cas_res_if res_ch ();
	cas_cfg_if cfg_ch ();

	cave_automaton_smoother uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rows    (row_ch),
		.results (res_ch),
		.cfg     (cfg_ch)
	);

	always #5 clk = ~clk;

	// Shadow registers and map of the predictor
	logic [CFG_W-1:0]    reg_width;
	logic [CFG_W-1:0]    reg_height;
	logic [LIMIT_W-1:0]  reg_birth;
	logic [LIMIT_W-1:0]  reg_death;
	logic [GEN_W-1:0]    reg_gens;
	logic [ROW_BITS-1:0] cave_rows [MAX_H];
	logic [ROW_BITS-1:0] pinned_cells [MAX_H];
	bit                  pinned_valid [MAX_H];
	int                  cave_loaded;

	frame_row_t  pending_rows [$];
	int          errors;
	int          items_sent;
	int unsigned gap_pct;
	int unsigned stall_pct;

	task automatic flag_mismatch(input string what);
		errors++;
		$display("mismatch at %0t ns: %s", $time, what);
	endtask

	function automatic int live_width();
		return (reg_width > MAX_W) ? MAX_W : int'(reg_width);
	endfunction

	function automatic int live_height();
		if (reg_height == 0)
			return 1;
		return (reg_height > MAX_H) ? MAX_H : int'(reg_height);
	endfunction

	function automatic logic [ROW_BITS-1:0] width_bits(input int w);
		return (w >= ROW_BITS) ? '1 : ((64'd1 << w) - 64'd1);
	endfunction

	// Off-map cells read as rock
	function automatic bit wall_at(input int x, input int y, input int w, input int h);
		if (x < 0 || y < 0 || x >= w || y >= h)
			return 1'b1;
		return cave_rows[y][x];
	endfunction

	// One birth/death generation over the whole map
	function automatic void smooth_once(input int w, input int h);
		logic [ROW_BITS-1:0] next_rows [MAX_H];
		int neighbours;
		for (int y = 0; y < h; y++) begin
			next_rows[y] = '0;
			for (int x = 0; x < w; x++) begin
				neighbours = 0;
				for (int dy = -1; dy <= 1; dy++)
					for (int dx = -1; dx <= 1; dx++)
						if (dx != 0 || dy != 0)
							neighbours += wall_at(x + dx, y + dy, w, h);
				if (wall_at(x, y, w, h))
					next_rows[y][x] = (neighbours >= reg_death);
				else
					next_rows[y][x] = (neighbours > reg_birth);
			end
		end
		for (int y = 0; y < h; y++)
			cave_rows[y] = next_rows[y];
	endfunction

	// Store one accepted row; on the row that completes a frame, queue the whole map
	function automatic void load_row(input logic [ROW_BITS-1:0] cells, input bit pinned,
		input logic [ROW_BITS-1:0] pin_value);
		int w;
		int h;
		logic [ROW_BITS-1:0] mask;
		frame_row_t r;
		w = live_width();
		h = live_height();
		mask = width_bits(w);
		cave_rows[cave_loaded] = cells & mask;
		pinned_valid[cave_loaded] = pinned;
		pinned_cells[cave_loaded] = pin_value;
		cave_loaded++;
		if (cave_loaded < h && cave_loaded < MAX_H)
			return;
		cave_loaded = 0;
		for (int y = 0; y < h; y++)
			cave_rows[y] &= mask;
		repeat (reg_gens)
			smooth_once(w, h);
		for (int y = 0; y < h; y++) begin
			r.cells = pinned_valid[y] ? pinned_cells[y] : (cave_rows[y] & mask);
			r.row = ROW_NUM_W'(y);
			r.is_last = (y == h - 1);
			pending_rows.push_back(r);
		end
		for (int y = 0; y < MAX_H; y++)
			pinned_valid[y] = 1'b0;
	endfunction

	// Row transaction; valid is left high so back-to-back rows need no reassertion
	task automatic send_row(input logic [ROW_BITS-1:0] cells, input bit pinned,
		input logic [ROW_BITS-1:0] pin_value);
		while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			row_ch.valid <= 1'b0;
			@(posedge clk);
		end
		row_ch.valid <= 1'b1;
		row_ch.row_cells <= cells;
		@(posedge clk);
		while (!row_ch.ready)
			@(posedge clk);
		items_sent++;
		load_row(cells, pinned, pin_value);
	endtask

	// Register write transaction; caller drops valid after the last one
	task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.reg_index <= sel;
		cfg_ch.wdata <= value;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		case (sel)
			REG_MAP_WIDTH:        reg_width = value;
			REG_MAP_HEIGHT:       reg_height = value;
			REG_BIRTH_LIMIT:      reg_birth = value[LIMIT_W-1:0];
			REG_DEATH_LIMIT:      reg_death = value[LIMIT_W-1:0];
			REG_GENERATION_COUNT: reg_gens = value[GEN_W-1:0];
			default: ;
		endcase
	endtask

	// Block goes idle: every queued row out, then a short settle
	task automatic wait_drained();
		row_ch.valid <= 1'b0;
		while (pending_rows.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic program_regs(input int unsigned w, input int unsigned h,
		input int unsigned b, input int unsigned d, input int unsigned g);
		wait_drained();
		write_reg(REG_MAP_WIDTH, CFG_DATA_W'(w));
		write_reg(REG_MAP_HEIGHT, CFG_DATA_W'(h));
		write_reg(REG_BIRTH_LIMIT, CFG_DATA_W'(b));
		write_reg(REG_DEATH_LIMIT, CFG_DATA_W'(d));
		write_reg(REG_GENERATION_COUNT, CFG_DATA_W'(g));
		cfg_ch.valid <= 1'b0;
	endtask

	// Mostly small maps and sane limits, with the odd extreme
	task automatic program_random_setting();
		int unsigned w;
		int unsigned h;
		int unsigned b;
		int unsigned d;
		int unsigned g;
		if ($urandom_range(0, 9) == 0) begin
			case ($urandom_range(0, 5))
				0: w = 0;
				1: w = 1;
				2: w = 2;
				3: w = 64;
				4: w = 65;
				default: w = 127;
			endcase
		end else
			w = $urandom_range(3, 64);
		case ($urandom_range(0, 19))
			0: h = 0;
			1: h = $urandom_range(9, 20);
			default: h = $urandom_range(1, 8);
		endcase
		b = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(2, 6);
		d = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 5);
		g = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 6);
		program_regs(w, h, b, d, g);
	endtask

	// Load rows until the frame completes, sometimes resizing part way through
	task automatic fill_frame();
		int unsigned density;
		logic [ROW_BITS-1:0] cells;
		bit resized;
		density = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 100) : $urandom_range(25, 75);
		resized = 1'b0;
		do begin
			if (!resized && cave_loaded != 0 && $urandom_range(0, 15) == 0) begin
				resized = 1'b1;
				wait_drained();
				if ($urandom_range(0, 1))
					write_reg(REG_MAP_HEIGHT, CFG_DATA_W'($urandom_range(0, 8)));
				else
					write_reg(REG_MAP_WIDTH, CFG_DATA_W'($urandom_range(0, 64)));
				cfg_ch.valid <= 1'b0;
			end
			if ($urandom_range(0, 9) == 0)
				cells = {$urandom, $urandom};
			else
				for (int i = 0; i < ROW_BITS; i++)
					cells[i] = ($urandom_range(0, 99) < density);
			send_row(cells, 1'b0, '0);
		end while (cave_loaded != 0);
	endtask

	// Receiver stalls
	always @(posedge clk)
		res_ch.ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);

	// Compare each result transaction with the oldest queued row
	always @(posedge clk) begin
		frame_row_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_rows.size() == 0)
				flag_mismatch($sformatf("row %0d arrived with nothing queued",
					res_ch.row_number));
			else begin
				want = pending_rows.pop_front();
				if (res_ch.out_cells !== want.cells)
					flag_mismatch($sformatf("row %0d out_cells %h, want %h",
						want.row, res_ch.out_cells, want.cells));
				if (res_ch.row_number !== want.row)
					flag_mismatch($sformatf("row_number %0d, want %0d",
						res_ch.row_number, want.row));
				if (res_ch.last_row !== want.is_last)
					flag_mismatch($sformatf("row %0d last_row %b, want %b",
						want.row, res_ch.last_row, want.is_last));
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("** cave_automaton_smoother: FAILED **");
		$finish;
	end

	initial begin
		int phase_start;
		bit first_frame;
		arst_n = 1'b0;
		row_ch.valid = 1'b0;
		row_ch.row_cells = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.reg_index = REG_MAP_WIDTH;
		cfg_ch.wdata = '0;
		res_ch.ready = 1'b0;
		gap_pct = 0;
		stall_pct = 0;
		errors = 0;
		items_sent = 0;
		cave_loaded = 0;
		reg_width = CFG_RESET.map_width;
		reg_height = CFG_RESET.map_height;
		reg_birth = CFG_RESET.birth_limit;
		reg_death = CFG_RESET.death_limit;
		reg_gens = CFG_RESET.generation_count;
		for (int y = 0; y < MAX_H; y++) begin
			cave_rows[y] = '0;
			pinned_cells[y] = '0;
			pinned_valid[y] = 1'b0;
		end
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;

		// Directed table
		for (int i = 0; i < DIRECTED_STEPS; i++) begin
			if (SCRIPT[i].kind == STEP_REG) begin
				if (i == 0 || SCRIPT[i-1].kind != STEP_REG)
					wait_drained();
				write_reg(SCRIPT[i].reg_sel, SCRIPT[i].value);
				if (i == DIRECTED_STEPS - 1 || SCRIPT[i+1].kind != STEP_REG)
					cfg_ch.valid <= 1'b0;
			end else
				send_row(SCRIPT[i].cells, SCRIPT[i].pinned, SCRIPT[i].want);
		end

		// Random frames under each idling pattern
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin gap_pct = 0; stall_pct = 0; end
				1: begin gap_pct = 75; stall_pct = 0; end
				2: begin gap_pct = 0; stall_pct = 75; end
				default: begin gap_pct = 34; stall_pct = 34; end
			endcase
			phase_start = items_sent;
			first_frame = 1'b1;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				if (first_frame && p == 1)
					program_regs(32'(CFG_RESET.map_width), 32'(CFG_RESET.map_height),
						32'(CFG_RESET.birth_limit), 32'(CFG_RESET.death_limit),
						32'(CFG_RESET.generation_count));
				else if (first_frame && p == 3)
					program_regs(127, 127, 4, 3, 15);
				else
					program_random_setting();
				first_frame = 1'b0;
				fill_frame();
			end
		end

		row_ch.valid <= 1'b0;
		while (pending_rows.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (errors == 0 && pending_rows.size() == 0)
			$display("** cave_automaton_smoother: PASSED **");
		else
			$display("** cave_automaton_smoother: FAILED **");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/cas_pkg.sv
rtl/cas_if.sv
rtl/cas_ram.sv
rtl/cas_rule.sv
rtl/cas_ctrl.sv
rtl/cave_automaton_smoother.sv
rtl/cas_checker.sv
tb/sv/tb_top.sv
